>>> rtl/core/swbr_pkg.sv
// Shared constants, types and helpers for the sliding window bit ratio block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package swbr_pkg;

  localparam int WINDOW_MAX    = 1024;
  localparam int POS_W         = $clog2(WINDOW_MAX);
  localparam int CNT_W         = 11;
  localparam int PCT_W         = 7;
  localparam int PROD_W        = CNT_W + PCT_W;
  localparam int STEP_W        = $clog2(PCT_W);
  localparam int LENGTH_RESET  = 1024;
  localparam int PERCENT_SCALE = 100;

  typedef struct packed {
    logic             cfg_write;
    logic [CNT_W-1:0] cfg_length;
    logic             update;
    logic             bit_in;
  } swbr_win_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] ones;
    logic [CNT_W-1:0] zeros;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] length;
  } swbr_win_stat_t;

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_UPDATE     = 6'b000010,
    S_ONES       = 6'b000100,
    S_WAIT_ONES  = 6'b001000,
    S_WAIT_ZEROS = 6'b010000,
    S_OUT        = 6'b100000
  } swbr_state_t;

  function automatic logic [PROD_W-1:0] scale_count(input logic [CNT_W-1:0] count);
    scale_count = PROD_W'(count) * PROD_W'(PERCENT_SCALE);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/swbr_div.sv
// Restoring serial divider, one quotient bit per cycle, PCT_W steps per run.
// Depends on swbr_pkg; the quotient must fit in PCT_W bits.
`timescale 1ns / 1ps
`default_nettype none

module swbr_div
  import swbr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output logic                   done,
  output logic [PCT_W-1:0]       quotient
);

  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] sh;
  logic [STEP_W-1:0] cnt;
  logic              active;
  logic              ge;

  assign ge = (rem >= sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
      done   <= 1'b0;
    end else if (active) begin
      if (cnt == '0) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      sh       <= PROD_W'(divisor) << (PCT_W - 1);
      cnt      <= STEP_W'(PCT_W - 1);
      quotient <= '0;
    end else if (active) begin
      if (ge) begin
        rem <= rem - sh;
      end
      sh       <= sh >> 1;
      cnt      <= cnt - 1'b1;
      quotient <= {quotient[PCT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/swbr_window.sv
// Circular bit store with read/write positions, fill level and ones/zeros totals.
// Depends on swbr_pkg; driven by the sequencer in the top level.
`timescale 1ns / 1ps
`default_nettype none

module swbr_window
  import swbr_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire swbr_win_ctrl_t ctrl,
  output swbr_win_stat_t      stat
);

  logic             mem [WINDOW_MAX];
  logic             rd_bit;
  logic [POS_W-1:0] oldest_pos;
  logic [POS_W-1:0] write_pos;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] ones;
  logic [CNT_W-1:0] zeros;
  logic [CNT_W-1:0] length;
  logic [CNT_W-1:0] length_next;
  logic             full;
  logic             drop_one;
  logic             drop_zero;

  function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos,
                                               input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(pos) + 1'b1;
    advance = (nxt >= len) ? '0 : nxt[POS_W-1:0];
  endfunction

  always_comb begin
    priority if (ctrl.cfg_length == '0) begin
      length_next = CNT_W'(1);
    end else if (ctrl.cfg_length > CNT_W'(WINDOW_MAX)) begin
      length_next = CNT_W'(WINDOW_MAX);
    end else begin
      length_next = ctrl.cfg_length;
    end
  end

  assign full      = (fill >= length);
  assign drop_one  = full && rd_bit && (ones != '0);
  assign drop_zero = full && !rd_bit && (zeros != '0);

  always_ff @(posedge clk) begin
    rd_bit <= mem[oldest_pos];
    if (ctrl.update) begin
      mem[write_pos] <= ctrl.bit_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length     <= CNT_W'(LENGTH_RESET);
      oldest_pos <= '0;
      write_pos  <= '0;
      fill       <= '0;
      ones       <= '0;
      zeros      <= '0;
    end else if (ctrl.cfg_write) begin
      length     <= length_next;
      oldest_pos <= '0;
      write_pos  <= '0;
      fill       <= '0;
      ones       <= '0;
      zeros      <= '0;
    end else if (ctrl.update) begin
      if (full) begin
        oldest_pos <= advance(oldest_pos, length);
      end else begin
        fill <= fill + 1'b1;
      end
      write_pos <= advance(write_pos, length);
      ones      <= ones - CNT_W'(drop_one) + CNT_W'(ctrl.bit_in);
      zeros     <= zeros - CNT_W'(drop_zero) + CNT_W'(!ctrl.bit_in);
    end
  end

  assign stat.ones   = ones;
  assign stat.zeros  = zeros;
  assign stat.fill   = fill;
  assign stat.length = length;

endmodule

`default_nettype wire

>>> rtl/core/sliding_window_bit_ratio.sv
// Sliding window bit ratio: one bit per beat, counts, fill and percentages out.
// A new beat is taken only in the idle state, after the previous beat has gone
// through two 7-step runs of the shared serial divider and the result load.
// The result register frees the sequencer while a result waits to be taken.
// Synchronous reset empties the window and sets the window length to 1024;
// the bit store itself is not cleared. Depends on swbr_pkg, swbr_window, swbr_div.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_bit_ratio
  import swbr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] window_length,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             bit_value,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [CNT_W-1:0]      ones_count,
  output logic [CNT_W-1:0]      zeros_count,
  output logic [CNT_W-1:0]      fill_count,
  output logic [PCT_W-1:0]      ones_percent,
  output logic [PCT_W-1:0]      zeros_percent
);

  swbr_state_t       state;
  swbr_state_t       state_next;
  swbr_win_ctrl_t    win_ctrl;
  swbr_win_stat_t    win_stat;
  logic              bit_reg;
  logic              div_start;
  logic              div_done;
  logic [PROD_W-1:0] div_dividend;
  logic [PCT_W-1:0]  div_quotient;
  logic [PCT_W-1:0]  ones_pct;
  logic [PCT_W-1:0]  zeros_pct;
  logic              in_accept;
  logic              out_load;

  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);

  assign win_ctrl.cfg_write  = cfg_valid && cfg_ready;
  assign win_ctrl.cfg_length = window_length;
  assign win_ctrl.update     = (state == S_UPDATE);
  assign win_ctrl.bit_in     = bit_reg;

  assign div_start    = (state == S_ONES) || ((state == S_WAIT_ONES) && div_done);
  assign div_dividend = (state == S_ONES) ? scale_count(win_stat.ones)
                                          : scale_count(win_stat.zeros);

  swbr_window u_window (
    .clk  (clk),
    .rst  (rst),
    .ctrl (win_ctrl),
    .stat (win_stat)
  );

  swbr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (win_stat.fill),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (in_accept) state_next = S_UPDATE;
      S_UPDATE:     state_next = S_ONES;
      S_ONES:       state_next = S_WAIT_ONES;
      S_WAIT_ONES:  if (div_done) state_next = S_WAIT_ZEROS;
      S_WAIT_ZEROS: if (div_done) state_next = S_OUT;
      S_OUT:        if (out_load) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      bit_reg <= bit_value;
    end
    if ((state == S_WAIT_ONES) && div_done) begin
      ones_pct <= div_quotient;
    end
    if ((state == S_WAIT_ZEROS) && div_done) begin
      zeros_pct <= div_quotient;
    end
    if (out_load) begin
      ones_count    <= win_stat.ones;
      zeros_count   <= win_stat.zeros;
      fill_count    <= win_stat.fill;
      ones_percent  <= ones_pct;
      zeros_percent <= zeros_pct;
    end
  end

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output step");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_WAIT_ONES || state == S_WAIT_ZEROS))
    else $error("divider finished while not awaited");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    win_stat.fill <= win_stat.length)
    else $error("window fill exceeds window length");

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    (win_stat.ones + win_stat.zeros) == win_stat.fill)
    else $error("ones and zeros do not add up to fill");

endmodule

`default_nettype wire
